// ===== rtl/btrf_pkg.sv =====
// Shared types and constants for the batch ticket ring FIFO.
// Used by btrf_ctrl, btrf_dp and batch_ticket_ring_fifo; no dependencies.
`timescale 1ns / 1ps

package btrf_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TICKET_W_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int OCC_W      = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int TDATA_W    = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CFG_IDX_START_TICKET = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_PUSHED   = 3'd0,
    STS_FULL     = 3'd1,
    STS_CLOSED   = 3'd2,
    STS_BADSIZE  = 3'd3,
    STS_NODATA   = 3'd4,
    STS_POPDATA  = 3'd5,
    STS_CLOSEACK = 3'd6
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic take;
    logic pop_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pop_go;
    logic pop_last;
  } dp_sts_t;

endpackage

// ===== rtl/batch_ticket_ring_fifo.sv =====
// Push and close answers appear in the cycle after the transfer; a pop shows
// its first element after the registered read port of the slot memory and
// the output register. Push and close items go one per cycle while the output
// is free; a pop holds the input until its last element is in the output register.
// Reset: synchronous, active low; clears tickets, closed flag and run state.
// The slot memory is not cleared. Depends on btrf_pkg, btrf_ctrl, btrf_dp.
`timescale 1ns / 1ps

module batch_ticket_ring_fifo #(
  parameter int DEPTH        = btrf_pkg::DEPTH_DEF,
  parameter int TICKET_WIDTH = btrf_pkg::TICKET_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [btrf_pkg::TDATA_W-1:0]        in_tdata,   // batch_count, value
  input  logic [btrf_pkg::OP_W-1:0]           in_tuser,   // operation
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [btrf_pkg::TDATA_W-1:0]        out_tdata,  // data_out, occupancy, is_closed
  output logic [btrf_pkg::STATUS_W-1:0]       out_tuser,  // status
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [btrf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [btrf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [btrf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  btrf_pkg::ctl_cmd_t              cmd;
  btrf_pkg::dp_sts_t               sts;
  btrf_pkg::status_t               out_status;
  logic [btrf_pkg::DATA_W-1:0]     out_data;
  logic [btrf_pkg::OCC_W-1:0]      out_occupancy;
  logic                            out_closed;
  logic [btrf_pkg::CFG_DATA_W-1:0] start_ticket;
  logic                            reg_hit;
  logic                            cfg_we;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == btrf_pkg::CFG_IDX_START_TICKET);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign cfg_prdata = reg_hit ? start_ticket : '0;

  btrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  btrf_dp #(
    .DEPTH        (DEPTH),
    .TICKET_WIDTH (TICKET_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_pwdata),
    .start_ticket   (start_ticket),
    .in_operation   (in_tuser),
    .in_batch_count (in_tdata[btrf_pkg::COUNT_W-1:0]),
    .in_value       (in_tdata[btrf_pkg::COUNT_W +: btrf_pkg::DATA_W]),
    .in_last        (in_tlast),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (out_status),
    .out_data       (out_data),
    .out_last       (out_tlast),
    .out_occupancy  (out_occupancy),
    .out_closed     (out_closed)
  );

  assign out_tuser = out_status;
  assign out_tdata = {2'b00, out_closed, out_occupancy, out_data};

endmodule

// ===== rtl/btrf_ctrl.sv =====
// Controller state machine of the batch ticket ring FIFO.
// Depends on btrf_pkg; drives commands into btrf_dp from its status.
`timescale 1ns / 1ps

module btrf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  btrf_pkg::dp_sts_t   sts,
  output btrf_pkg::ctl_cmd_t  cmd
);

  btrf_pkg::state_t state_r;
  btrf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btrf_pkg::ST_IDLE: begin
        if (in_tvalid && sts.out_free && sts.pop_go) begin
          state_nxt = btrf_pkg::ST_POP;
        end
      end
      btrf_pkg::ST_POP: begin
        if (sts.out_free && sts.pop_last) begin
          state_nxt = btrf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.pop_emit = 1'b0;
    unique case (state_r)
      btrf_pkg::ST_IDLE: begin
        in_tready = sts.out_free;
        cmd.take  = in_tvalid && sts.out_free;
      end
      btrf_pkg::ST_POP: begin
        cmd.pop_emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/btrf_dp.sv =====
// Datapath of the batch ticket ring FIFO: tickets, run tracking, slot memory
// and output register. Depends on btrf_pkg; commanded by btrf_ctrl.
`timescale 1ns / 1ps

module btrf_dp #(
  parameter int DEPTH        = btrf_pkg::DEPTH_DEF,
  parameter int TICKET_WIDTH = btrf_pkg::TICKET_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btrf_pkg::ctl_cmd_t                  cmd,
  output btrf_pkg::dp_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [btrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [btrf_pkg::CFG_DATA_W-1:0]     start_ticket,
  input  logic [btrf_pkg::OP_W-1:0]           in_operation,
  input  logic [btrf_pkg::COUNT_W-1:0]        in_batch_count,
  input  logic [btrf_pkg::DATA_W-1:0]         in_value,
  input  logic                                in_last,
  input  logic                                out_tready,
  output logic                                out_valid,
  output btrf_pkg::status_t                   out_status,
  output logic [btrf_pkg::DATA_W-1:0]         out_data,
  output logic                                out_last,
  output logic [btrf_pkg::OCC_W-1:0]          out_occupancy,
  output logic                                out_closed
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = TICKET_WIDTH;
  localparam int CMP_W = ((TW > 17) ? TW : 17) + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [btrf_pkg::DATA_W-1:0] mem [DEPTH];

  logic [TW-1:0]                   wr_ticket_r, wr_ticket_nxt;
  logic [TW-1:0]                   rd_ticket_r, rd_ticket_nxt;
  logic                            closed_r, closed_nxt;
  logic                            in_run_r, in_run_nxt;
  btrf_pkg::status_t               run_status_r, run_status_nxt;
  logic [TW-1:0]                   run_base_r, run_base_nxt;
  logic [btrf_pkg::COUNT_W-1:0]    run_size_r, run_size_nxt;
  logic [btrf_pkg::COUNT_W-1:0]    run_written_r, run_written_nxt;
  logic [btrf_pkg::CFG_DATA_W-1:0] start_ticket_r, start_ticket_nxt;
  logic [btrf_pkg::COUNT_W-1:0]    remaining_r, remaining_nxt;
  logic [IDX_W-1:0]                rd_addr_r, rd_addr_nxt;
  logic [btrf_pkg::DATA_W-1:0]     rdata_r;

  logic                            out_valid_r, out_valid_nxt;
  btrf_pkg::status_t               out_status_r, out_status_nxt;
  logic [btrf_pkg::DATA_W-1:0]     out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [btrf_pkg::OCC_W-1:0]      out_occ_r, out_occ_nxt;
  logic                            out_closed_r, out_closed_nxt;

  logic [TW-1:0]                   occ_cur;
  logic [TW-1:0]                   occ_nxt;
  logic [CMP_W-1:0]                occ_ext;
  logic [CMP_W-1:0]                count_ext;
  logic                            size_bad;
  logic                            room_bad;
  logic                            data_short;
  btrf_pkg::status_t               first_status;
  btrf_pkg::status_t               eff_status;
  logic [TW-1:0]                   eff_base;
  logic [btrf_pkg::COUNT_W-1:0]    eff_size;
  logic [btrf_pkg::COUNT_W-1:0]    eff_written;
  logic                            push_wr;
  logic [btrf_pkg::COUNT_W-1:0]    written_new;
  logic [TW-1:0]                   slot_ticket;
  logic                            mem_we;
  logic                            out_load;

  assign occ_cur    = wr_ticket_r - rd_ticket_r;
  assign occ_ext    = CMP_W'(occ_cur);
  assign count_ext  = CMP_W'(in_batch_count);
  assign size_bad   = (in_batch_count == '0) || (count_ext > DEPTH_C);
  assign room_bad   = (occ_ext + count_ext) > DEPTH_C;
  assign data_short = occ_ext < count_ext;

  always_comb begin
    if (size_bad) begin
      first_status = btrf_pkg::STS_BADSIZE;
    end else if (closed_r) begin
      first_status = btrf_pkg::STS_CLOSED;
    end else if (room_bad) begin
      first_status = btrf_pkg::STS_FULL;
    end else begin
      first_status = btrf_pkg::STS_PUSHED;
    end
  end

  assign eff_status  = in_run_r ? run_status_r  : first_status;
  assign eff_base    = in_run_r ? run_base_r    : wr_ticket_r;
  assign eff_size    = in_run_r ? run_size_r    : in_batch_count;
  assign eff_written = in_run_r ? run_written_r : '0;
  assign push_wr     = (eff_status == btrf_pkg::STS_PUSHED) && (eff_written < eff_size);
  assign written_new = eff_written + btrf_pkg::COUNT_W'(push_wr);
  assign slot_ticket = eff_base + TW'(eff_written);

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.pop_go   = (in_operation == btrf_pkg::OP_POP) && !size_bad && !data_short;
  assign sts.pop_last = (remaining_r == btrf_pkg::COUNT_W'(1));

  always_comb begin
    wr_ticket_nxt    = wr_ticket_r;
    rd_ticket_nxt    = rd_ticket_r;
    closed_nxt       = closed_r;
    in_run_nxt       = in_run_r;
    run_status_nxt   = run_status_r;
    run_base_nxt     = run_base_r;
    run_size_nxt     = run_size_r;
    run_written_nxt  = run_written_r;
    start_ticket_nxt = start_ticket_r;
    remaining_nxt    = remaining_r;
    rd_addr_nxt      = rd_addr_r;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    out_status_nxt   = out_status_r;
    out_data_nxt     = '0;
    out_last_nxt     = 1'b1;

    if (cfg_we) begin
      wr_ticket_nxt    = TW'(cfg_data);
      rd_ticket_nxt    = TW'(cfg_data);
      start_ticket_nxt = cfg_data;
      in_run_nxt       = 1'b0;
      run_status_nxt   = btrf_pkg::STS_PUSHED;
      run_size_nxt     = '0;
      run_written_nxt  = '0;
    end else if (cmd.take) begin
      case (in_operation)
        btrf_pkg::OP_PUSH: begin
          run_status_nxt  = eff_status;
          run_base_nxt    = eff_base;
          run_size_nxt    = eff_size;
          run_written_nxt = written_new;
          mem_we          = push_wr;
          if (in_last) begin
            in_run_nxt     = 1'b0;
            out_load       = 1'b1;
            out_status_nxt = eff_status;
            if (eff_status == btrf_pkg::STS_PUSHED) begin
              wr_ticket_nxt = eff_base + TW'(written_new);
            end
          end else begin
            in_run_nxt = 1'b1;
          end
        end
        btrf_pkg::OP_POP: begin
          if (size_bad) begin
            out_load       = 1'b1;
            out_status_nxt = btrf_pkg::STS_BADSIZE;
          end else if (data_short) begin
            out_load       = 1'b1;
            out_status_nxt = btrf_pkg::STS_NODATA;
          end else begin
            rd_ticket_nxt = rd_ticket_r + TW'(in_batch_count);
            remaining_nxt = in_batch_count;
            rd_addr_nxt   = rd_ticket_r[IDX_W-1:0];
          end
        end
        btrf_pkg::OP_CLOSE: begin
          closed_nxt     = 1'b1;
          out_load       = 1'b1;
          out_status_nxt = btrf_pkg::STS_CLOSEACK;
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end else if (cmd.pop_emit) begin
      out_load       = 1'b1;
      out_status_nxt = btrf_pkg::STS_POPDATA;
      out_data_nxt   = rdata_r;
      out_last_nxt   = sts.pop_last;
      remaining_nxt  = remaining_r - btrf_pkg::COUNT_W'(1);
      rd_addr_nxt    = rd_addr_r + IDX_W'(1);
    end

    occ_nxt        = wr_ticket_nxt - rd_ticket_nxt;
    out_occ_nxt    = occ_nxt[btrf_pkg::OCC_W-1:0];
    out_closed_nxt = closed_nxt;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ticket_r    <= '0;
      rd_ticket_r    <= '0;
      closed_r       <= 1'b0;
      in_run_r       <= 1'b0;
      run_status_r   <= btrf_pkg::STS_PUSHED;
      run_base_r     <= '0;
      run_size_r     <= '0;
      run_written_r  <= '0;
      start_ticket_r <= '0;
      remaining_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      wr_ticket_r    <= wr_ticket_nxt;
      rd_ticket_r    <= rd_ticket_nxt;
      closed_r       <= closed_nxt;
      in_run_r       <= in_run_nxt;
      run_status_r   <= run_status_nxt;
      run_base_r     <= run_base_nxt;
      run_size_r     <= run_size_nxt;
      run_written_r  <= run_written_nxt;
      start_ticket_r <= start_ticket_nxt;
      remaining_r    <= remaining_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
      out_occ_r    <= out_occ_nxt;
      out_closed_r <= out_closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_ticket[IDX_W-1:0]] <= in_value;
    end
    rdata_r <= mem[rd_addr_nxt];
  end

  assign start_ticket  = start_ticket_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occ_r;
  assign out_closed    = out_closed_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_ext <= DEPTH_C)
    else $error("held elements exceed ring depth");

  a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_emit |-> (remaining_r != '0))
    else $error("pop element emitted with nothing remaining");

  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.pop_go && !cfg_we) |=> (remaining_r != '0))
    else $error("accepted pop left no elements to deliver");

  a_run_written: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (run_written_r <= run_size_r))
    else $error("push run wrote beyond its declared size");

endmodule
